// ----- hw/rtl/frnt_pkg.sv -----
// Shared types, widths and codes for the fixed-radius neighbor table.
// No dependencies; frnt_dist and the top module refer to it by scoped names.
package frnt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int POS_W       = 16;
    localparam int DIFF_W      = POS_W + 1;
    localparam int SQ_W        = 2 * POS_W + 1;
    localparam int DIST_W      = 34;
    localparam int STATUS_W    = 3;

    // 99999.0 in Q26.8
    localparam logic [DIST_W-1:0] DIST_RESET = 34'd25599744;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd5;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic            valid;
        logic            match;
        logic [ID_W-1:0] id;
    } dist_res_t;

endpackage

// ----- hw/rtl/frnt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; sized by its parameters only.
module frnt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/frnt_dist.sv -----
// Squared-distance stage: registered squares of dx and dy, then sum and
// threshold compare. Depends on frnt_pkg.
module frnt_dist (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [frnt_pkg::POS_W-1:0]  q_x,
    input  logic signed [frnt_pkg::POS_W-1:0]  q_y,
    input  frnt_pkg::entry_t                   entry,
    input  logic [frnt_pkg::DIST_W-1:0]        thr,
    output frnt_pkg::dist_res_t                res
);

    logic signed [frnt_pkg::DIFF_W-1:0]   dx;
    logic signed [frnt_pkg::DIFF_W-1:0]   dy;
    logic signed [2*frnt_pkg::DIFF_W-1:0] px;
    logic signed [2*frnt_pkg::DIFF_W-1:0] py;
    logic [frnt_pkg::SQ_W-1:0]            sq_x_reg;
    logic [frnt_pkg::SQ_W-1:0]            sq_y_reg;
    logic [frnt_pkg::ID_W-1:0]            id_reg;
    logic                                 valid_reg;
    logic [frnt_pkg::DIST_W-1:0]          dist_sum;

    assign dx = frnt_pkg::DIFF_W'(entry.x) - frnt_pkg::DIFF_W'(q_x);
    assign dy = frnt_pkg::DIFF_W'(entry.y) - frnt_pkg::DIFF_W'(q_y);
    assign px = dx * dx;
    assign py = dy * dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // squares are non-negative and at most 2^32
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg <= px[frnt_pkg::SQ_W-1:0];
            sq_y_reg <= py[frnt_pkg::SQ_W-1:0];
            id_reg   <= entry.id;
        end
    end

    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    assign res.valid = valid_reg;
    assign res.match = dist_sum < thr;
    assign res.id    = id_reg;

endmodule

// ----- hw/rtl/fixed_radius_neighbor_table.sv -----
// Fixed-radius neighbor table: sequencer, table RAM and distance stage.
// Report: id search scan, write unless the table is full, then one result.
// Query: id search; if found, a full distance scan, one entry per cycle unless stalled;
// neighbors stream one per cycle, and the scan holds while a second match waits on a
// result register not yet taken. One item at a time. Synchronous active-low reset
// empties the table (count 0) and loads the threshold with 99999.0; RAM is not cleared.
module fixed_radius_neighbor_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [frnt_pkg::ID_W-1:0]           s_node_id,
    input  logic signed [frnt_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [frnt_pkg::POS_W-1:0]   s_pos_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [frnt_pkg::STATUS_W-1:0]       m_status,
    output logic [frnt_pkg::ID_W-1:0]           m_neighbor_id,
    output logic                                m_last,
    input  logic                                cfg_wr_en,
    input  logic [frnt_pkg::DIST_W-1:0]         cfg_wr_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRCH   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [frnt_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [frnt_pkg::CNT_W-1:0]         addr_reg, addr_next;
    logic                               v1_reg, v1_next;
    logic [frnt_pkg::ADDR_W-1:0]        idx1_reg, idx1_next;
    logic                               found_reg, found_next;
    logic [frnt_pkg::ADDR_W-1:0]        hit_idx_reg, hit_idx_next;
    logic signed [frnt_pkg::POS_W-1:0]  qx_reg, qx_next;
    logic signed [frnt_pkg::POS_W-1:0]  qy_reg, qy_next;
    logic                               kind_reg, kind_next;
    logic [frnt_pkg::ID_W-1:0]          id_reg, id_next;
    logic signed [frnt_pkg::POS_W-1:0]  px_reg, px_next;
    logic signed [frnt_pkg::POS_W-1:0]  py_reg, py_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [frnt_pkg::ID_W-1:0]          pend_id_reg, pend_id_next;
    logic [frnt_pkg::STATUS_W-1:0]      emit_status_reg, emit_status_next;
    logic [frnt_pkg::ID_W-1:0]          emit_id_reg, emit_id_next;
    logic                               m_valid_reg, m_valid_next;
    logic [frnt_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [frnt_pkg::ID_W-1:0]          m_id_reg, m_id_next;
    logic                               m_last_reg, m_last_next;
    logic [frnt_pkg::DIST_W-1:0]        max_dist_sq_reg;

    frnt_pkg::entry_t                   rd_data;
    frnt_pkg::entry_t                   wr_data;
    frnt_pkg::dist_res_t                dres;
    logic                               rd_en;
    logic                               wr_en;
    logic [frnt_pkg::ADDR_W-1:0]        wr_addr;
    logic                               out_free;
    logic                               hit_now;
    logic                               issue;
    logic                               stall;
    logic                               adv;
    logic                               has_room;
    logic                               push;

    assign out_free = !m_valid_reg || m_ready;
    assign has_room = count_reg < frnt_pkg::CNT_W'(frnt_pkg::TABLE_DEPTH);
    assign hit_now  = (state_reg == S_SRCH) && v1_reg && (rd_data.id == id_reg);
    assign issue    = (((state_reg == S_SRCH) && !hit_now) || (state_reg == S_SCAN))
                      && (addr_reg < count_reg);
    // a second match cannot pass the pending one while the result register is busy
    assign stall    = (state_reg == S_SCAN) && dres.valid && dres.match
                      && pend_valid_reg && !out_free;
    assign adv      = !stall;
    assign rd_en    = issue && adv;
    assign push     = (state_reg == S_SCAN) && adv && dres.valid && dres.match
                      && pend_valid_reg;

    assign wr_en    = (state_reg == S_DECIDE) && (kind_reg == frnt_pkg::KIND_REPORT)
                      && (found_reg || has_room);
    assign wr_addr  = found_reg ? hit_idx_reg : count_reg[frnt_pkg::ADDR_W-1:0];
    assign wr_data  = '{id: id_reg, x: px_reg, y: py_reg};

    frnt_ram #(
        .DEPTH (frnt_pkg::TABLE_DEPTH),
        .WIDTH (frnt_pkg::ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[frnt_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    frnt_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v1_reg && (state_reg == S_SCAN)),
        .q_x      (qx_reg),
        .q_y      (qy_reg),
        .entry    (rd_data),
        .thr      (max_dist_sq_reg),
        .res      (dres)
    );

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        v1_next          = v1_reg;
        idx1_next        = idx1_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        emit_status_next = emit_status_reg;
        emit_id_next     = emit_id_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_id_next        = m_id_reg;
        m_last_next      = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    id_next    = s_node_id;
                    px_next    = s_pos_x;
                    py_next    = s_pos_y;
                    addr_next  = '0;
                    found_next = 1'b0;
                    v1_next    = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                v1_next = issue;
                if (rd_en) begin
                    addr_next = addr_reg + 1'b1;
                    idx1_next = addr_reg[frnt_pkg::ADDR_W-1:0];
                end
                if (hit_now) begin
                    found_next   = 1'b1;
                    hit_idx_next = idx1_reg;
                    qx_next      = rd_data.x;
                    qy_next      = rd_data.y;
                    v1_next      = 1'b0;
                    state_next   = S_DECIDE;
                end else if (!issue && !v1_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                emit_id_next = '0;
                if (kind_reg == frnt_pkg::KIND_REPORT) begin
                    if (found_reg) begin
                        emit_status_next = frnt_pkg::ST_UPDATED;
                    end else if (has_room) begin
                        emit_status_next = frnt_pkg::ST_INSERTED;
                        count_next       = count_reg + 1'b1;
                    end else begin
                        emit_status_next = frnt_pkg::ST_FULL;
                    end
                    state_next = S_EMIT;
                end else if (!found_reg) begin
                    emit_status_next = frnt_pkg::ST_NOTFOUND;
                    state_next       = S_EMIT;
                end else begin
                    addr_next       = '0;
                    v1_next         = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    v1_next = issue;
                end
                if (rd_en) begin
                    addr_next = addr_reg + 1'b1;
                end
                // hold one match back so the final one can carry last
                if (adv && dres.valid && dres.match) begin
                    pend_valid_next = 1'b1;
                    pend_id_next    = dres.id;
                end
                if (push) begin
                    m_valid_next  = 1'b1;
                    m_status_next = frnt_pkg::ST_NEIGHBOR;
                    m_id_next     = pend_id_reg;
                    m_last_next   = 1'b0;
                end
                if (!issue && !v1_reg && !dres.valid) begin
                    emit_status_next = pend_valid_reg ? frnt_pkg::ST_NEIGHBOR
                                                      : frnt_pkg::ST_NONE;
                    emit_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = emit_status_reg;
                    m_id_next     = emit_id_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            v1_reg          <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_dist_sq_reg <= frnt_pkg::DIST_RESET;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            v1_reg         <= v1_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                max_dist_sq_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg        <= addr_next;
        idx1_reg        <= idx1_next;
        found_reg       <= found_next;
        hit_idx_reg     <= hit_idx_next;
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        pend_id_reg     <= pend_id_next;
        emit_status_reg <= emit_status_next;
        emit_id_reg     <= emit_id_next;
        m_status_reg    <= m_status_next;
        m_id_reg        <= m_id_next;
        m_last_reg      <= m_last_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_neighbor_id = m_id_reg;
    assign m_last        = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= frnt_pkg::CNT_W'(frnt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("neighbor beat overwrote a pending result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(pend_id_reg) && $stable(addr_reg))
        else $error("scan advanced during stall");

    a_accept_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_SRCH) && !m_valid_reg ||
        (state_reg == S_SRCH))
        else $error("accepted item did not start a search");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != frnt_pkg::ST_NEIGHBOR)) |-> (m_neighbor_id == '0))
        else $error("non-neighbor beat carries an id");

    a_not_last_neighbor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == frnt_pkg::ST_NEIGHBOR))
        else $error("only neighbor beats may continue an item");

endmodule
